### rtl/gnd_pkg.sv
// ----------------------------------------------------------------------------
// gnd_pkg
// shared widths, result codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam int SLOTS     = 8;
  localparam int SLOT_W    = 3;
  localparam int DENOM_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int AMT_W     = 24;
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // result codes carried on the output tuser
  typedef enum logic [1:0] {
    ST_DISPENSED = 2'd0,
    ST_FAILED    = 2'd1,
    ST_LOADED    = 2'd2
  } status_t;

  typedef logic [SLOTS-1:0][DENOM_W-1:0] denom_tbl_t;

  // controller -> datapath commands
  typedef struct packed {
    logic    capture;
    logic    load_wr;
    logic    slot_init;
    logic    slot_skip;
    logic    div_init;
    logic    div_step;
    logic    mul;
    logic    slot_done;
    logic    emit_init;
    logic    emit_adv;
    status_t rsp_status;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_load;
    logic denom_zero;
    logic div_last;
    logic idx_last;
    logic pay_ok;
    logic take_nz;
  } dp_sts_t;

  typedef struct packed {
    status_t             status;
    logic [DENOM_W-1:0]  note_value;
    logic [COUNT_W-1:0]  note_count;
    logic                last;
  } res_t;

endpackage

### rtl/gnd_dp.sv
// ----------------------------------------------------------------------------
// gnd_dp
// note inventory, bit-serial divider, take multiplier and result assembly
// ----------------------------------------------------------------------------
module gnd_dp #(
  parameter int NUM_DENOMS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gnd_pkg::dp_cmd_t              cmd,
  output gnd_pkg::dp_sts_t              sts,
  input  gnd_pkg::denom_tbl_t           denom_tbl,
  input  logic                          req_type,
  input  logic [gnd_pkg::SLOT_W-1:0]    slot,
  input  logic [gnd_pkg::AMT_W-1:0]     request_value,
  output gnd_pkg::res_t                 res
);
  import gnd_pkg::*;

  logic                 type_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [AMT_W-1:0]     amt_r;
  logic [AMT_W-1:0]     rem_r;
  logic [AMT_W-1:0]     q_r;
  logic [DENOM_W-1:0]   r_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [COUNT_W-1:0]   take_r;
  logic [2*DENOM_W-1:0] prod_r;
  logic [SLOTS-1:0]     used_r;
  logic [COUNT_W-1:0]   takes_r  [SLOTS];
  logic [COUNT_W-1:0]   counts_r [SLOTS];

  logic [DENOM_W-1:0]   cur_denom;
  logic [COUNT_W-1:0]   cur_count;
  logic [DENOM_W:0]     r_sh;
  logic                 r_ge;
  logic [DENOM_W:0]     r_dif;
  logic [COUNT_W-1:0]   take_nxt;
  logic [COUNT_W-1:0]   load_nxt;
  logic [SLOTS-1:0]     higher_used;

  assign cur_denom = denom_tbl[idx_r];
  assign cur_count = counts_r[idx_r];

  // one quotient bit per step, partial remainder stays below the divisor
  assign r_sh  = {r_r, q_r[AMT_W-1]};
  assign r_ge  = r_sh >= {1'b0, cur_denom};
  assign r_dif = r_sh - {1'b0, cur_denom};

  assign take_nxt = (q_r > AMT_W'(cur_count)) ? cur_count : q_r[COUNT_W-1:0];
  assign load_nxt = (amt_r > AMT_W'(COUNT_MAX)) ? COUNT_MAX : amt_r[COUNT_W-1:0];

  assign higher_used = used_r & ~((SLOTS'(2) << idx_r) - SLOTS'(1));

  // control and inventory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
      used_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (cmd.load_wr && ({1'b0, slot_r} < (SLOT_W+1)'(NUM_DENOMS))) begin
        counts_r[slot_r] <= load_nxt;
      end
      if (cmd.slot_init) begin
        rem_r  <= amt_r;
        idx_r  <= '0;
        used_r <= '0;
      end
      if (cmd.slot_skip) begin
        used_r[idx_r] <= 1'b0;
        idx_r         <= idx_r + 1'b1;
      end
      if (cmd.div_init) begin
        cnt_r <= '0;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.slot_done) begin
        rem_r         <= rem_r - prod_r[AMT_W-1:0];
        used_r[idx_r] <= take_r != '0;
        idx_r         <= idx_r + 1'b1;
      end
      if (cmd.emit_init) begin
        idx_r <= '0;
      end
      if (cmd.emit_adv) begin
        if (takes_r[idx_r] != '0) begin
          counts_r[idx_r] <= counts_r[idx_r] - takes_r[idx_r];
        end
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= req_type;
      slot_r <= slot;
      amt_r  <= request_value;
    end
    if (cmd.div_init) begin
      q_r <= rem_r;
      r_r <= '0;
    end
    if (cmd.div_step) begin
      q_r <= {q_r[AMT_W-2:0], r_ge};
      r_r <= r_ge ? r_dif[DENOM_W-1:0] : r_sh[DENOM_W-1:0];
    end
    if (cmd.mul) begin
      take_r <= take_nxt;
      prod_r <= take_nxt * cur_denom;
    end
    if (cmd.slot_skip) begin
      takes_r[idx_r] <= '0;
    end
    if (cmd.slot_done) begin
      takes_r[idx_r] <= take_r;
    end
  end

  always_comb begin
    sts.is_load    = type_r;
    sts.denom_zero = cur_denom == '0;
    sts.div_last   = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
    sts.idx_last   = idx_r == SLOT_W'(NUM_DENOMS - 1);
    sts.pay_ok     = (rem_r == '0) && (amt_r != '0);
    sts.take_nz    = takes_r[idx_r] != '0;
  end

  always_comb begin
    res.status = cmd.rsp_status;
    if (cmd.rsp_status == ST_DISPENSED) begin
      res.note_value = cur_denom;
      res.note_count = takes_r[idx_r];
      res.last       = higher_used == '0;
    end else begin
      res.note_value = '0;
      res.note_count = '0;
      res.last       = 1'b1;
    end
  end

endmodule

### rtl/gnd_ctrl.sv
// ----------------------------------------------------------------------------
// gnd_ctrl
// request sequencer: load, greedy slot walk, commit and result emission
// ----------------------------------------------------------------------------
module gnd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  gnd_pkg::dp_sts_t  sts,
  output gnd_pkg::dp_cmd_t  cmd,
  output logic              push,
  output logic              idle
);
  import gnd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_DIV,
    S_MUL,
    S_SUB,
    S_CHECK,
    S_FAIL,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rsp_status = ST_DISPENSED;
    push           = 1'b0;
    idle           = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle        = 1'b1;
        cmd.capture = in_fire;
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_load) begin
          cmd.load_wr = 1'b1;
          state_nxt   = S_LOAD;
        end else begin
          cmd.slot_init = 1'b1;
          state_nxt     = S_SLOT;
        end
      end
      S_SLOT: begin
        if (sts.denom_zero) begin
          cmd.slot_skip = 1'b1;
          state_nxt     = sts.idx_last ? S_CHECK : S_SLOT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.slot_done = 1'b1;
        state_nxt     = sts.idx_last ? S_CHECK : S_SLOT;
      end
      S_CHECK: begin
        if (sts.pay_ok) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_FAIL: begin
        cmd.rsp_status = ST_FAILED;
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.rsp_status = ST_LOADED;
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // slots that gave nothing are stepped over without a beat
        if (!sts.take_nz || out_free) begin
          push         = sts.take_nz;
          cmd.emit_adv = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/greedy_note_dispenser_core.sv
// ----------------------------------------------------------------------------
// greedy_note_dispenser_core
// greedy cash payout from a limited note inventory over eight denominations
// ----------------------------------------------------------------------------
// sequence: a load is written and answered after its beat is accepted; a
//   withdrawal walks NUM_DENOMS slots, stepping over an unused slot and sending
//   a used one through the 24-step bit-serial divider, one multiply and one
//   subtract, then a check and a commit-and-emit pass that waits on the output
// throughput: one request at a time; the next beat is taken once the sequencer
//   is back in idle, right after the last push or after the emit pass ends
// reset: synchronous active-low rst_n clears denominations, note counts and
//   control state; no clearing pass is needed
// ----------------------------------------------------------------------------
module greedy_note_dispenser_core #(
  parameter int NUM_DENOMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [2:0] slot, [26:3] request_value, rest zero
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] note_value, [31:16] note_count
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gnd_pkg::*;

  denom_tbl_t denom_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  res_t       res;
  res_t       out_res_r;
  logic       out_valid_r;
  logic       out_free;
  logic       push;
  logic       idle;
  logic       in_fire;
  logic       cfg_wr;
  logic [SLOT_W-1:0] cfg_idx;

  // ---------------------------------------------------------------------------
  // denomination registers, one per word
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = 32'(denom_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      denom_r <= '0;
    end else if (cfg_wr) begin
      denom_r[cfg_idx] <= cfg_pwdata[DENOM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // controller and datapath
  // ---------------------------------------------------------------------------
  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  // output register can take a beat when empty or draining this cycle
  assign out_free  = !out_valid_r || out_tready;

  gnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .push     (push),
    .idle     (idle)
  );

  gnd_dp #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .denom_tbl     (denom_r),
    .req_type      (in_tuser),
    .slot          (in_tdata[SLOT_W-1:0]),
    .request_value (in_tdata[SLOT_W+AMT_W-1:SLOT_W]),
    .res           (res)
  );

  // ---------------------------------------------------------------------------
  // output register, decouples the result side from the sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.note_count, out_res_r.note_value};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a request is decoded before any further beat may enter
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input beat taken while a request is in flight");

  // failure and load answers are single beats with empty data
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FAILED || out_tuser == ST_LOADED))
      |-> (out_tlast && out_tdata == 32'd0))
    else $error("failure or load result not a lone empty beat");

  // every dispensed beat pays at least one note of a real denomination
  a_dispense_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_DISPENSED)
      |-> (out_tdata[15:0] != 16'd0 && out_tdata[31:16] != 16'd0))
    else $error("dispensed beat with zero value or count");

  // a new beat is only pushed into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over an unconsumed beat");

endmodule
